// ----- design/opd_pkg.sv -----
// opd_pkg: shared types and constants for the ogg page deframer
// holds the transfer structs, result kind codes and the capture pattern
// no dependencies
package opd_pkg;

  localparam int OPD_MAX_SEGMENTS = 255;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // capture pattern "OggS"
  localparam logic [7:0] CAPTURE_PATTERN [4] = '{8'h4F, 8'h67, 8'h67, 8'h53};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_stream;
  } opd_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  stream_version;
    logic [7:0]  page_flags;
    logic [63:0] granule_position;
    logic [31:0] serial_number;
    logic [31:0] sequence_number;
    logic [31:0] stored_checksum;
    logic [7:0]  segment_count;
    logic [15:0] payload_length;
    logic        segment_done;
    logic        page_done;
  } opd_out_t;

endpackage

// ----- design/opd_lacing_mem.sv -----
// opd_lacing_mem: lacing value store, one write and one registered read port
// a write to the entry being read in the same cycle is forwarded
// depends on nothing
module opd_lacing_mem #(
  parameter int DEPTH = 255,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] lace_mem_r [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lace_mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= lace_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/opd_parser.sv -----
// opd_parser: page header state machine and payload sequencer
// keeps nonzero lacing values compacted in opd_lacing_mem, next one read ahead
// depends on opd_pkg, opd_lacing_mem
module opd_parser #(
  parameter int MAX_SEGMENTS = opd_pkg::OPD_MAX_SEGMENTS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_take,
  input  opd_pkg::opd_in_t in_item,
  output logic             res_valid,
  output opd_pkg::opd_out_t res_item
);
  import opd_pkg::*;

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  localparam logic [3:0] PH_SIG     = 4'd0;
  localparam logic [3:0] PH_VERSION = 4'd1;
  localparam logic [3:0] PH_TYPE    = 4'd2;
  localparam logic [3:0] PH_GRANULE = 4'd3;
  localparam logic [3:0] PH_SERIAL  = 4'd4;
  localparam logic [3:0] PH_SEQ     = 4'd5;
  localparam logic [3:0] PH_CRC     = 4'd6;
  localparam logic [3:0] PH_SEGCNT  = 4'd7;
  localparam logic [3:0] PH_LACING  = 4'd8;
  localparam logic [3:0] PH_PAYLOAD = 4'd9;

  logic [3:0]    phase_r, phase_nxt;
  logic [3:0]    fcnt_r, fcnt_nxt;
  logic [63:0]   granule_r, granule_nxt;
  logic [31:0]   serial_r, serial_nxt;
  logic [31:0]   seq_r, seq_nxt;
  logic [31:0]   crc_r, crc_nxt;
  logic [7:0]    version_r, version_nxt;
  logic [7:0]    flags_r, flags_nxt;
  logic [7:0]    segcnt_r, segcnt_nxt;
  logic [7:0]    seg_idx_r, seg_idx_nxt;
  logic [15:0]   total_r, total_nxt;
  logic [CW-1:0] nz_cnt_r, nz_cnt_nxt;
  logic [CW-1:0] nxt_idx_r, nxt_idx_nxt;
  logic [7:0]    first_len_r, first_len_nxt;
  logic [7:0]    cur_left_r, cur_left_nxt;
  logic          lock_r, lock_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic [7:0]    b;
  logic [7:0]    left;
  logic          hdr_done;
  logic          emit;
  logic [1:0]    kind;
  logic          seg_done;
  logic          pg_done;

  assign b       = in_item.data_byte;
  assign left    = cur_left_r - 8'd1;
  assign wr_addr = nz_cnt_r[AW-1:0];
  // read one segment ahead; clamp to entry zero once the index reaches MAX_SEGMENTS
  assign rd_addr = (nxt_idx_nxt < CW'(MAX_SEGMENTS)) ? nxt_idx_nxt[AW-1:0] : '0;

  opd_lacing_mem #(
    .DEPTH (MAX_SEGMENTS),
    .AW    (AW)
  ) u_lacing_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (b),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    phase_nxt     = phase_r;
    fcnt_nxt      = fcnt_r;
    granule_nxt   = granule_r;
    serial_nxt    = serial_r;
    seq_nxt       = seq_r;
    crc_nxt       = crc_r;
    version_nxt   = version_r;
    flags_nxt     = flags_r;
    segcnt_nxt    = segcnt_r;
    seg_idx_nxt   = seg_idx_r;
    total_nxt     = total_r;
    nz_cnt_nxt    = nz_cnt_r;
    nxt_idx_nxt   = nxt_idx_r;
    first_len_nxt = first_len_r;
    cur_left_nxt  = cur_left_r;
    lock_nxt      = lock_r;
    wr_en         = 1'b0;
    hdr_done      = 1'b0;
    emit          = 1'b0;
    kind          = KIND_HEADER;
    seg_done      = 1'b0;
    pg_done       = 1'b0;

    if (in_take && !lock_r) begin
      unique case (phase_r) inside
        PH_SIG: begin
          if (b != CAPTURE_PATTERN[fcnt_r[1:0]]) begin
            lock_nxt = 1'b1;
            emit     = 1'b1;
            kind     = KIND_ERROR;
          end else begin
            fcnt_nxt = fcnt_r + 4'd1;
            if (fcnt_nxt >= 4'd4) begin
              fcnt_nxt  = 4'd0;
              phase_nxt = PH_VERSION;
            end
          end
        end
        PH_VERSION: begin
          version_nxt = b;
          phase_nxt   = PH_TYPE;
        end
        PH_TYPE: begin
          flags_nxt = b;
          fcnt_nxt  = 4'd0;
          phase_nxt = PH_GRANULE;
        end
        PH_GRANULE: begin
          granule_nxt = {b, granule_r[63:8]};
          fcnt_nxt    = fcnt_r + 4'd1;
          if (fcnt_nxt >= 4'd8) begin
            fcnt_nxt  = 4'd0;
            phase_nxt = PH_SERIAL;
          end
        end
        PH_SERIAL, PH_SEQ, PH_CRC: begin
          if (phase_r == PH_SERIAL) begin
            serial_nxt = {b, serial_r[31:8]};
          end else if (phase_r == PH_SEQ) begin
            seq_nxt = {b, seq_r[31:8]};
          end else begin
            crc_nxt = {b, crc_r[31:8]};
          end
          fcnt_nxt = fcnt_r + 4'd1;
          if (fcnt_nxt >= 4'd4) begin
            fcnt_nxt  = 4'd0;
            phase_nxt = phase_r + 4'd1;
          end
        end
        PH_SEGCNT: begin
          segcnt_nxt    = b;
          seg_idx_nxt   = 8'd0;
          total_nxt     = 16'd0;
          cur_left_nxt  = 8'd0;
          nz_cnt_nxt    = '0;
          first_len_nxt = 8'd0;
          if (b == 8'd0) begin
            hdr_done = 1'b1;
          end else begin
            phase_nxt = PH_LACING;
          end
        end
        PH_LACING: begin
          if (seg_idx_r < 8'(MAX_SEGMENTS)) begin
            total_nxt = total_r + {8'd0, b};
            // only nonzero lengths are kept, packed from entry zero
            if (b != 8'd0) begin
              wr_en      = 1'b1;
              nz_cnt_nxt = nz_cnt_r + CW'(1);
              if (nz_cnt_r == '0) begin
                first_len_nxt = b;
              end
            end
          end
          seg_idx_nxt = seg_idx_r + 8'd1;
          if (seg_idx_nxt >= segcnt_r) begin
            hdr_done = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          emit = 1'b1;
          kind = KIND_PAYLOAD;
          if (left != 8'd0) begin
            cur_left_nxt = left;
          end else begin
            seg_done = 1'b1;
            if (nxt_idx_r < nz_cnt_r) begin
              cur_left_nxt = rd_data;
              nxt_idx_nxt  = nxt_idx_r + CW'(1);
            end else begin
              pg_done   = 1'b1;
              phase_nxt = PH_SIG;
              fcnt_nxt  = 4'd0;
            end
          end
        end
        default: begin
          phase_nxt = PH_SIG;
          fcnt_nxt  = 4'd0;
        end
      endcase

      if (hdr_done) begin
        emit = 1'b1;
        kind = KIND_HEADER;
        if (nz_cnt_nxt == '0) begin
          pg_done   = 1'b1;
          phase_nxt = PH_SIG;
          fcnt_nxt  = 4'd0;
        end else begin
          cur_left_nxt = first_len_nxt;
          nxt_idx_nxt  = CW'(1);
          phase_nxt    = PH_PAYLOAD;
        end
      end

      if (in_item.last_in_stream && !lock_nxt) begin
        phase_nxt = PH_SIG;
        fcnt_nxt  = 4'd0;
      end
    end
  end

  always_comb begin
    res_valid = emit;
    res_item  = '0;
    res_item.result_kind  = kind;
    res_item.segment_done = seg_done;
    res_item.page_done    = pg_done;
    if (kind != KIND_ERROR) begin
      res_item.payload_byte     = (kind == KIND_PAYLOAD) ? b : 8'd0;
      res_item.stream_version   = version_nxt;
      res_item.page_flags       = flags_nxt;
      res_item.granule_position = granule_nxt;
      res_item.serial_number    = serial_nxt;
      res_item.sequence_number  = seq_nxt;
      res_item.stored_checksum  = crc_nxt;
      res_item.segment_count    = segcnt_nxt;
      res_item.payload_length   = total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SIG;
      fcnt_r      <= 4'd0;
      granule_r   <= 64'd0;
      serial_r    <= 32'd0;
      seq_r       <= 32'd0;
      crc_r       <= 32'd0;
      version_r   <= 8'd0;
      flags_r     <= 8'd0;
      segcnt_r    <= 8'd0;
      seg_idx_r   <= 8'd0;
      total_r     <= 16'd0;
      nz_cnt_r    <= '0;
      nxt_idx_r   <= '0;
      first_len_r <= 8'd0;
      cur_left_r  <= 8'd0;
      lock_r      <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      fcnt_r      <= fcnt_nxt;
      granule_r   <= granule_nxt;
      serial_r    <= serial_nxt;
      seq_r       <= seq_nxt;
      crc_r       <= crc_nxt;
      version_r   <= version_nxt;
      flags_r     <= flags_nxt;
      segcnt_r    <= segcnt_nxt;
      seg_idx_r   <= seg_idx_nxt;
      total_r     <= total_nxt;
      nz_cnt_r    <= nz_cnt_nxt;
      nxt_idx_r   <= nxt_idx_nxt;
      first_len_r <= first_len_nxt;
      cur_left_r  <= cur_left_nxt;
      lock_r      <= lock_nxt;
    end
  end

endmodule

// ----- design/ogg_page_deframer_core.sv -----
// Ogg page deframer takes one stream byte per cycle and returns at most one result per byte
// (header, payload byte or error). Each byte's result is formed combinationally, appearing
// in the output register on the next clock, so pages stream at one byte per cycle.
// Nonzero lacing values are packed into a MAX_SEGMENTS-entry memory and the next segment's
// length is read one step ahead, which keeps segment switches at full rate even for 1-byte
// segments. The input stalls only while a held result is stalled downstream.
// A capture-pattern mismatch gives one error result and locks the block until reset.
module ogg_page_deframer_core #(
  parameter int MAX_SEGMENTS = opd_pkg::OPD_MAX_SEGMENTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  opd_pkg::opd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output opd_pkg::opd_out_t out_data
);
  import opd_pkg::*;

  logic     in_take;
  logic     res_valid;
  opd_out_t res_item;
  logic     out_valid_r, out_valid_nxt;
  opd_out_t out_data_r;

  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  opd_parser #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (in_take),
    .in_item   (in_data),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_take && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register loads only when a new result is produced
  always_ff @(posedge clk) begin
    if (in_take && res_valid) begin
      out_data_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- test/ogg_page_deframer_core_tb.sv -----
`timescale 1ns / 1ps
// testbench for ogg_page_deframer_core: streams directed and random ogg pages byte by byte
// and checks each result against a behavioral model of the deframer kept in this file, or against a fixed
// expected result for typed header rows and the capture error; depends on opd_pkg and the core module
module ogg_page_deframer_core_tb;
  import opd_pkg::*;

  localparam logic [31:0] OGG_MAGIC = 32'h4F67_6753;
  localparam int NO_CUT = -1;
  localparam int CUT_LAST = -2;
  localparam int RANDOM_BYTES = 250;
  localparam int DIR_ROWS = 16;

  typedef enum logic [3:0] {
    ST_HUNT, ST_VERSION, ST_FLAGS, ST_GRANULE, ST_SERIAL,
    ST_SEQNO, ST_CHECKSUM, ST_SEGCOUNT, ST_LACING, ST_PAYLOAD
  } parse_state_e;

  typedef enum int {LACE_ZERO, LACE_ONE, LACE_MAX, LACE_SMALL, LACE_ANY} lace_mode_e;
  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  // one page to stream; version, flags, granule, serial, seq_num and checksum are only used as given when typed is set
  typedef struct packed {
    bit          typed;
    logic [7:0]  version;
    logic [7:0]  flags;
    logic [63:0] granule;
    logic [31:0] serial;
    logic [31:0] seq_num;
    logic [31:0] checksum;
    logic [7:0]  seg_count;
    lace_mode_e  lace;
    int          cut_at;
  } page_row_t;

  page_row_t dir_rows [DIR_ROWS] = '{
    '{1'b1, 8'h00, 8'h00, 64'h0, 32'h0, 32'h0, 32'h0, 8'd0, LACE_ZERO, NO_CUT},
    '{1'b1, 8'hFF, 8'hFF, 64'hFFFFFFFFFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
      8'd0, LACE_ZERO, NO_CUT},
    '{1'b1, 8'h01, 8'h02, 64'h0123456789ABCDEF, 32'h0A0B0C0D, 32'h00000001, 32'h5A5AA5A5,
      8'd5, LACE_ZERO, NO_CUT},
    '{1'b1, 8'h00, 8'h04, 64'h8000000000000001, 32'h80000001, 32'h7FFFFFFF, 32'h0000FFFF,
      8'd17, LACE_ZERO, NO_CUT},
    '{1'b1, 8'h7F, 8'h01, 64'hFEDCBA9876543210, 32'h12345678, 32'h9ABCDEF0, 32'hFFFF0000,
      8'd255, LACE_MAX, 285},
    '{1'b0, 8'h00, 8'h00, 64'h0, 32'h0, 32'h0, 32'h0, 8'd32, LACE_ONE, NO_CUT},
    '{1'b0, 8'h00, 8'h00, 64'h0, 32'h0, 32'h0, 32'h0, 8'd3, LACE_ONE, NO_CUT},
    '{1'b0, 8'h00, 8'h00, 64'h0, 32'h0, 32'h0, 32'h0, 8'd6, LACE_SMALL, NO_CUT},
    '{1'b0, 8'h00, 8'h00, 64'h0, 32'h0, 32'h0, 32'h0, 8'd1, LACE_ANY, NO_CUT},
    '{1'b0, 8'h00, 8'h00, 64'h0, 32'h0, 32'h0, 32'h0, 8'd1, LACE_SMALL, 2},
    '{1'b0, 8'h00, 8'h00, 64'h0, 32'h0, 32'h0, 32'h0, 8'd1, LACE_ONE, 9},
    '{1'b0, 8'h00, 8'h00, 64'h0, 32'h0, 32'h0, 32'h0, 8'd0, LACE_ZERO, 26},
    '{1'b0, 8'h00, 8'h00, 64'h0, 32'h0, 32'h0, 32'h0, 8'd6, LACE_ONE, 29},
    '{1'b0, 8'h00, 8'h00, 64'h0, 32'h0, 32'h0, 32'h0, 8'd2, LACE_ONE, 28},
    '{1'b0, 8'h00, 8'h00, 64'h0, 32'h0, 32'h0, 32'h0, 8'd2, LACE_MAX, 60},
    '{1'b0, 8'h00, 8'h00, 64'h0, 32'h0, 32'h0, 32'h0, 8'd3, LACE_SMALL, CUT_LAST}
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  opd_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  opd_out_t out_data;

  // deframer model state
  parse_state_e pg_phase = ST_HUNT;
  int           field_count = 0;
  logic [63:0]  granule_sr = '0;
  logic [31:0]  serial_sr = '0;
  logic [31:0]  seqno_sr = '0;
  logic [31:0]  checksum_sr = '0;
  logic [7:0]   version_q = '0;
  logic [7:0]   flags_q = '0;
  logic [7:0]   page_segs = '0;
  logic [7:0]   lace_mem [OPD_MAX_SEGMENTS];
  logic [7:0]   seg_idx = '0;
  logic [7:0]   seg_left = '0;
  logic [15:0]  payload_sum = '0;
  bit           locked = 1'b0;

  opd_out_t results_due [$];
  int       mismatch_count = 0;
  int       results_checked = 0;
  int       bytes_sent = 0;
  int       pages_sent = 0;
  int       pages_cut = 0;
  int       burst_left = 0;
  rx_mode_e rx_mode = RX_FREE;
  int       rx_timer = 0;

  ogg_page_deframer_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] magic_byte(int k);
    return OGG_MAGIC[31 - 8 * (k & 3) -: 8];
  endfunction

  function automatic int stored_segments();
    return (page_segs < OPD_MAX_SEGMENTS) ? int'(page_segs) : OPD_MAX_SEGMENTS;
  endfunction

  // first stored segment at or after start with a nonzero length
  function automatic int first_live_segment(int start);
    int lim;
    int i;
    lim = stored_segments();
    for (i = start; i < lim; i++) begin
      if (lace_mem[i] != 8'h00) return i;
    end
    return lim;
  endfunction

  function automatic opd_out_t page_result(logic [1:0] kind, logic [7:0] b, logic seg_end,
                                           logic page_end);
    opd_out_t r;
    r.result_kind      = kind;
    r.payload_byte     = b;
    r.stream_version   = version_q;
    r.page_flags       = flags_q;
    r.granule_position = granule_sr;
    r.serial_number    = serial_sr;
    r.sequence_number  = seqno_sr;
    r.stored_checksum  = checksum_sr;
    r.segment_count    = page_segs;
    r.payload_length   = payload_sum;
    r.segment_done     = seg_end;
    r.page_done        = page_end;
    return r;
  endfunction

  task automatic close_header(output opd_out_t res);
    int idx;
    idx = first_live_segment(0);
    if (idx >= stored_segments()) begin
      res = page_result(KIND_HEADER, 8'h00, 1'b0, 1'b1);
      pg_phase = ST_HUNT;
      field_count = 0;
    end else begin
      res = page_result(KIND_HEADER, 8'h00, 1'b0, 1'b0);
      seg_idx = idx[7:0];
      seg_left = lace_mem[idx];
      pg_phase = ST_PAYLOAD;
    end
  endtask

  task automatic deframe_byte(input opd_in_t it, output bit got, output opd_out_t res);
    logic [7:0] b;
    int idx;
    b = it.data_byte;
    got = 1'b0;
    res = '0;
    if (locked) return;
    case (pg_phase)
      ST_HUNT: begin
        if (b != magic_byte(field_count)) begin
          locked = 1'b1;
          res.result_kind = KIND_ERROR;
          got = 1'b1;
          return;
        end
        field_count = (field_count + 1) & 15;
        if (field_count >= 4) begin
          field_count = 0;
          pg_phase = ST_VERSION;
        end
      end
      ST_VERSION: begin
        version_q = b;
        pg_phase = ST_FLAGS;
      end
      ST_FLAGS: begin
        flags_q = b;
        field_count = 0;
        pg_phase = ST_GRANULE;
      end
      ST_GRANULE: begin
        granule_sr = {b, granule_sr[63:8]};
        field_count++;
        if (field_count >= 8) begin
          field_count = 0;
          pg_phase = ST_SERIAL;
        end
      end
      ST_SERIAL, ST_SEQNO, ST_CHECKSUM: begin
        if (pg_phase == ST_SERIAL) serial_sr = {b, serial_sr[31:8]};
        else if (pg_phase == ST_SEQNO) seqno_sr = {b, seqno_sr[31:8]};
        else checksum_sr = {b, checksum_sr[31:8]};
        field_count++;
        if (field_count >= 4) begin
          field_count = 0;
          pg_phase = (pg_phase == ST_SERIAL) ? ST_SEQNO :
                     (pg_phase == ST_SEQNO) ? ST_CHECKSUM : ST_SEGCOUNT;
        end
      end
      ST_SEGCOUNT: begin
        page_segs = b;
        seg_idx = '0;
        payload_sum = '0;
        seg_left = '0;
        if (b == 8'h00) begin
          close_header(res);
          got = 1'b1;
        end else begin
          pg_phase = ST_LACING;
        end
      end
      ST_LACING: begin
        if (seg_idx < OPD_MAX_SEGMENTS) begin
          lace_mem[seg_idx] = b;
          payload_sum = payload_sum + {8'h00, b};
        end
        seg_idx = seg_idx + 8'd1;
        if (seg_idx >= page_segs) begin
          close_header(res);
          got = 1'b1;
        end
      end
      ST_PAYLOAD: begin
        seg_left = seg_left - 8'd1;
        if (seg_left != 8'd0) begin
          res = page_result(KIND_PAYLOAD, b, 1'b0, 1'b0);
        end else begin
          idx = first_live_segment(int'(seg_idx) + 1);
          if (idx >= stored_segments()) begin
            res = page_result(KIND_PAYLOAD, b, 1'b1, 1'b1);
            pg_phase = ST_HUNT;
            field_count = 0;
          end else begin
            res = page_result(KIND_PAYLOAD, b, 1'b1, 1'b0);
            seg_idx = idx[7:0];
            seg_left = lace_mem[idx];
          end
        end
        got = 1'b1;
      end
      default: begin
        pg_phase = ST_HUNT;
        field_count = 0;
      end
    endcase
    if (it.last_in_stream) begin
      pg_phase = ST_HUNT;
      field_count = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s at result %0d: got %h, expected %h", what, results_checked, got,
             want);
    mismatch_count++;
  endtask

  // one input transfer; the expectation is queued as soon as the byte is taken
  task automatic send_byte(input logic [7:0] b, input logic last, input bit fixed,
                           input opd_out_t fixed_res);
    opd_in_t  item;
    opd_out_t res;
    bit       got;
    int       gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    item.data_byte = b;
    item.last_in_stream = last;
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
    bytes_sent++;
    deframe_byte(item, got, res);
    if (fixed) results_due.push_back(fixed_res);
    else if (got) results_due.push_back(res);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  task automatic send_page(input page_row_t row);
    logic [7:0] page_bytes [$];
    logic [7:0] lace;
    opd_out_t   hdr_res;
    int         payload_len;
    int         hdr_at;
    int         cut;
    int         i;
    if (!row.typed) begin
      row.version = 8'($urandom_range(0, 255));
      row.flags = 8'($urandom_range(0, 255));
      row.granule = {$urandom, $urandom};
      row.serial = $urandom;
      row.seq_num = $urandom;
      row.checksum = $urandom;
    end
    for (i = 0; i < 4; i++) page_bytes.push_back(magic_byte(i));
    page_bytes.push_back(row.version);
    page_bytes.push_back(row.flags);
    for (i = 0; i < 8; i++) page_bytes.push_back(row.granule[8 * i +: 8]);
    for (i = 0; i < 4; i++) page_bytes.push_back(row.serial[8 * i +: 8]);
    for (i = 0; i < 4; i++) page_bytes.push_back(row.seq_num[8 * i +: 8]);
    for (i = 0; i < 4; i++) page_bytes.push_back(row.checksum[8 * i +: 8]);
    page_bytes.push_back(row.seg_count);
    payload_len = 0;
    for (i = 0; i < row.seg_count; i++) begin
      case (row.lace)
        LACE_ZERO:  lace = 8'd0;
        LACE_ONE:   lace = 8'd1;
        LACE_MAX:   lace = 8'hFF;
        LACE_SMALL: lace = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 8));
        default:    lace = 8'($urandom_range(0, 255));
      endcase
      page_bytes.push_back(lace);
      payload_len += lace;
    end
    hdr_at = page_bytes.size() - 1;
    for (i = 0; i < payload_len; i++) page_bytes.push_back(8'($urandom_range(0, 255)));
    cut = (row.cut_at == CUT_LAST) ? page_bytes.size() - 1 : row.cut_at;
    hdr_res = '0;
    hdr_res.result_kind = KIND_HEADER;
    hdr_res.stream_version = row.version;
    hdr_res.page_flags = row.flags;
    hdr_res.granule_position = row.granule;
    hdr_res.serial_number = row.serial;
    hdr_res.sequence_number = row.seq_num;
    hdr_res.stored_checksum = row.checksum;
    hdr_res.segment_count = row.seg_count;
    hdr_res.payload_length = payload_len[15:0];
    hdr_res.page_done = (payload_len == 0);
    for (i = 0; i < page_bytes.size(); i++) begin
      if (cut >= 0 && i > cut) break;
      send_byte(page_bytes[i], i == cut, row.typed && i == hdr_at, hdr_res);
    end
    pages_sent++;
    if (cut >= 0 && cut < page_bytes.size()) pages_cut++;
  endtask

  initial begin : stimulus
    page_row_t  row;
    opd_out_t   err_res;
    int         rand_start;
    int         sig_ok;
    int         tail_start;
    int         r;
    bit         paused;
    logic [7:0] bad;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (r = 0; r < DIR_ROWS; r++) send_page(dir_rows[r]);

    // mostly small well-formed pages, some cut short by last_in_stream
    rand_start = bytes_sent;
    paused = 1'b0;
    while (bytes_sent - rand_start < RANDOM_BYTES) begin
      row = '0;
      row.seg_count = 8'($urandom_range(0, 6));
      case ($urandom_range(0, 11))
        0: begin
          row.lace = LACE_ANY;
          row.seg_count = 8'($urandom_range(1, 2));
        end
        1: row.lace = LACE_ONE;
        2: row.lace = LACE_ZERO;
        default: row.lace = LACE_SMALL;
      endcase
      row.cut_at = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 40)) : NO_CUT;
      send_page(row);
      if (!paused && bytes_sent - rand_start >= RANDOM_BYTES / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    // bad capture pattern on a last byte, then nothing may wake the parser
    wait_drained();
    sig_ok = $urandom_range(0, 3);
    for (r = 0; r < sig_ok; r++) send_byte(magic_byte(r), 1'b0, 1'b0, '0);
    bad = magic_byte(sig_ok) ^ (8'h01 << $urandom_range(0, 7));
    err_res = '0;
    err_res.result_kind = KIND_ERROR;
    tail_start = bytes_sent;
    send_byte(bad, 1'b1, 1'b1, err_res);
    row = '0;
    row.seg_count = 8'd3;
    row.lace = LACE_ONE;
    row.cut_at = CUT_LAST;
    send_page(row);
    send_byte(magic_byte(0), 1'b1, 1'b0, '0);
    wait_drained();
    repeat (20) @(posedge clk);

    $display("%0d pages streamed (%0d cut short), %0d bytes accepted, %0d results checked",
             pages_sent, pages_cut, bytes_sent, results_checked);
    $display("capture error after %0d good bytes, then %0d bytes ignored while locked",
             sig_ok, bytes_sent - tail_start - 1);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  always @(posedge clk) begin : result_check
    opd_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result kind", {62'd0, out_data.result_kind}, 64'd0);
      end else begin
        want = results_due.pop_front();
        results_checked++;
        if (out_data.result_kind !== want.result_kind)
          report_mismatch("result_kind", out_data.result_kind, want.result_kind);
        if (out_data.payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", out_data.payload_byte, want.payload_byte);
        if (out_data.stream_version !== want.stream_version)
          report_mismatch("stream_version", out_data.stream_version, want.stream_version);
        if (out_data.page_flags !== want.page_flags)
          report_mismatch("page_flags", out_data.page_flags, want.page_flags);
        if (out_data.granule_position !== want.granule_position)
          report_mismatch("granule_position", out_data.granule_position,
                          want.granule_position);
        if (out_data.serial_number !== want.serial_number)
          report_mismatch("serial_number", out_data.serial_number, want.serial_number);
        if (out_data.sequence_number !== want.sequence_number)
          report_mismatch("sequence_number", out_data.sequence_number, want.sequence_number);
        if (out_data.stored_checksum !== want.stored_checksum)
          report_mismatch("stored_checksum", out_data.stored_checksum, want.stored_checksum);
        if (out_data.segment_count !== want.segment_count)
          report_mismatch("segment_count", out_data.segment_count, want.segment_count);
        if (out_data.payload_length !== want.payload_length)
          report_mismatch("payload_length", out_data.payload_length, want.payload_length);
        if (out_data.segment_done !== want.segment_done)
          report_mismatch("segment_done", out_data.segment_done, want.segment_done);
        if (out_data.page_done !== want.page_done)
          report_mismatch("page_done", out_data.page_done, want.page_done);
      end
    end
    // receiver switches to a randomly chosen stall pattern whenever its timer runs out
    if (rx_timer == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_timer = $urandom_range(16, 96);
    end else begin
      rx_timer--;
    end
    case (rx_mode)
      RX_FREE:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
      default:  out_stall <= ((rx_timer % 8) < 3);
    endcase
  end

  initial begin : watchdog
    #50_000_000;
    $display("timeout with %0d results still due", results_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
